// ----- rtl/lca_pkg.sv -----
// shared types and constants for the lowest common ancestor engine
`default_nettype none
package lca_pkg;

  localparam int MAX_NODES_DEF = 1024;
  localparam int LEVELS_DEF    = 10;

  localparam int FIELD_W = 10;
  localparam int COUNT_W = 11;
  localparam int DIST_W  = 11;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BUILD = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef struct packed {
    logic               valid;
    logic [FIELD_W-1:0] ancestor;
    logic [DIST_W-1:0]  distance;
    logic               is_answer;
  } lca_res_t;

endpackage
`default_nettype wire

// ----- rtl/lca_ram.sv -----
// generic simple dual port ram with registered read
`default_nettype none
module lca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- rtl/lca_ctrl.sv -----
// sequencer for load, table build and query over the ancestor and depth memories
`default_nettype none
module lca_ctrl import lca_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int LEVELS    = LEVELS_DEF,
  localparam int NW = $clog2(MAX_NODES),
  localparam int EW = NW + 1,
  localparam int AW = $clog2(LEVELS * MAX_NODES)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               out_free_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         operation_i,
  input  wire logic [FIELD_W-1:0] first_node_i,
  input  wire logic [FIELD_W-1:0] second_node_i,
  input  wire logic               has_parent_i,
  input  wire logic [FIELD_W-1:0] node_depth_i,
  input  wire logic [COUNT_W-1:0] node_count_i,
  output logic                    tab_we_o,
  output logic      [AW-1:0]      tab_waddr_o,
  output logic      [EW-1:0]      tab_wdata_o,
  output logic      [AW-1:0]      tab_raddr_o,
  input  wire logic [EW-1:0]      tab_rdata_i,
  output logic                    dep_we_o,
  output logic      [NW-1:0]      dep_waddr_o,
  output logic      [FIELD_W-1:0] dep_wdata_o,
  output logic      [NW-1:0]      dep_raddr_o,
  input  wire logic [FIELD_W-1:0] dep_rdata_i,
  output lca_res_t                res_o
);

  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_BRD    = 16'h0002,
    S_BL1    = 16'h0004,
    S_BL2    = 16'h0008,
    S_QDA    = 16'h0010,
    S_QDB    = 16'h0020,
    S_QLIFT  = 16'h0040,
    S_QLIFTW = 16'h0080,
    S_QCMP   = 16'h0100,
    S_QDL    = 16'h0200,
    S_QDLW   = 16'h0400,
    S_QDHW   = 16'h0800,
    S_QTOP   = 16'h1000,
    S_QTOPW  = 16'h2000,
    S_QDT    = 16'h4000,
    S_QDTW   = 16'h8000
  } state_e;

  state_e             state_q, state_d;
  logic [LW-1:0]      k_q, k_d;
  logic [NW-1:0]      i_q, i_d;
  logic [NW:0]        n_q, n_d;
  logic [NW-1:0]      a_q, a_d, b_q, b_d;
  logic [FIELD_W-1:0] da_q, da_d, db_q, db_d, diff_q, diff_d;
  logic [EW-1:0]      lo_q, lo_d, hi_q, hi_d, pl_q, pl_d, top_q, top_d;

  // index modulo MAX_NODES, compare and subtract from the top multiple down
  function automatic logic [NW-1:0] node_of(input logic [FIELD_W-1:0] x);
    logic [31:0] r;
    r = 32'(x);
    for (int j = FIELD_W - 1; j >= 0; j--) begin
      if (r >= (32'(MAX_NODES) << j)) begin
        r = r - (32'(MAX_NODES) << j);
      end
    end
    return r[NW-1:0];
  endfunction

  function automatic logic [AW-1:0] tab_addr(input logic [31:0] k, input logic [NW-1:0] n);
    return AW'(k * 32'(MAX_NODES) + 32'(n));
  endfunction

  function automatic logic [NW-1:0] ent2node(input logic [EW-1:0] e);
    logic [EW-1:0] t;
    t = e - EW'(1);
    return t[NW-1:0];
  endfunction

  assign in_ready_o = (state_q == S_IDLE) && out_free_i;

  always_comb begin
    logic               accept;
    logic               b_adv;
    logic               q_adv;
    logic [FIELD_W-1:0] db;
    logic [EW-1:0]      ph;
    logic [FIELD_W-1:0] dt;
    logic [12:0]        sum;
    logic signed [13:0] sd;
    logic [NW:0]        ncl;

    accept = in_valid_i && in_ready_o;
    b_adv  = 1'b0;
    q_adv  = 1'b0;
    db     = dep_rdata_i;
    ph     = '0;
    dt     = '0;
    sum    = '0;
    sd     = '0;
    ncl    = (32'(node_count_i) > MAX_NODES) ? (NW+1)'(MAX_NODES) : (NW+1)'(node_count_i);

    state_d = state_q;
    k_d = k_q; i_d = i_q; n_d = n_q; a_d = a_q; b_d = b_q;
    da_d = da_q; db_d = db_q; diff_d = diff_q;
    lo_d = lo_q; hi_d = hi_q; pl_d = pl_q; top_d = top_q;

    tab_we_o = 1'b0; tab_waddr_o = '0; tab_wdata_o = '0; tab_raddr_o = '0;
    dep_we_o = 1'b0; dep_waddr_o = '0; dep_wdata_o = '0; dep_raddr_o = '0;
    res_o = '0;

    unique case (state_q)
      S_IDLE: begin
        dep_raddr_o = node_of(first_node_i);
        if (accept) begin
          unique case (op_e'(operation_i))
            OP_LOAD: begin
              tab_we_o    = 1'b1;
              tab_waddr_o = tab_addr(32'd0, node_of(first_node_i));
              tab_wdata_o = has_parent_i ? EW'(node_of(second_node_i)) + EW'(1) : '0;
              dep_we_o    = 1'b1;
              dep_waddr_o = node_of(first_node_i);
              dep_wdata_o = node_depth_i;
              res_o.valid = 1'b1;
            end
            OP_BUILD: begin
              n_d = ncl;
              k_d = '0;
              i_d = '0;
              if (ncl == '0 || LEVELS < 2) begin
                res_o.valid = 1'b1;
              end else begin
                state_d = S_BRD;
              end
            end
            OP_QUERY: begin
              a_d = node_of(first_node_i);
              b_d = node_of(second_node_i);
              state_d = S_QDA;
            end
            OP_NONE: begin
              res_o.valid = 1'b1;
            end
          endcase
        end
      end
      S_BRD: begin
        tab_raddr_o = tab_addr(32'(k_q), i_q);
        state_d = S_BL1;
      end
      S_BL1: begin
        if (tab_rdata_i == '0) begin
          tab_we_o    = 1'b1;
          tab_waddr_o = tab_addr(32'(k_q) + 32'd1, i_q);
          tab_wdata_o = '0;
          b_adv = 1'b1;
        end else begin
          tab_raddr_o = tab_addr(32'(k_q), ent2node(tab_rdata_i));
          state_d = S_BL2;
        end
      end
      S_BL2: begin
        tab_we_o    = 1'b1;
        tab_waddr_o = tab_addr(32'(k_q) + 32'd1, i_q);
        tab_wdata_o = tab_rdata_i;
        b_adv = 1'b1;
      end
      S_QDA: begin
        da_d = dep_rdata_i;
        dep_raddr_o = b_q;
        state_d = S_QDB;
      end
      S_QDB: begin
        db_d = db;
        k_d  = '0;
        // the deeper node goes to hi and gets lifted
        if (da_q > db) begin
          lo_d = EW'(b_q) + EW'(1);
          hi_d = EW'(a_q) + EW'(1);
          diff_d = da_q - db;
        end else begin
          lo_d = EW'(a_q) + EW'(1);
          hi_d = EW'(b_q) + EW'(1);
          diff_d = db - da_q;
        end
        state_d = S_QLIFT;
      end
      S_QLIFT: begin
        if (diff_q[0] && hi_q != '0) begin
          tab_raddr_o = tab_addr(32'(k_q), ent2node(hi_q));
          state_d = S_QLIFTW;
        end else begin
          q_adv = 1'b1;
        end
      end
      S_QLIFTW: begin
        hi_d = tab_rdata_i;
        q_adv = 1'b1;
      end
      S_QCMP: begin
        if (lo_q == hi_q) begin
          top_d = lo_q;
          state_d = S_QDT;
        end else begin
          k_d = LW'(LEVELS - 1);
          state_d = S_QDL;
        end
      end
      S_QDL: begin
        tab_raddr_o = tab_addr(32'(k_q), ent2node(lo_q));
        state_d = S_QDLW;
      end
      S_QDLW: begin
        pl_d = (lo_q != '0) ? tab_rdata_i : '0;
        tab_raddr_o = tab_addr(32'(k_q), ent2node(hi_q));
        state_d = S_QDHW;
      end
      S_QDHW: begin
        ph = (hi_q != '0) ? tab_rdata_i : '0;
        if (pl_q != ph) begin
          lo_d = pl_q;
          hi_d = ph;
        end
        if (k_q == '0) begin
          state_d = S_QTOP;
        end else begin
          k_d = k_q - LW'(1);
          state_d = S_QDL;
        end
      end
      S_QTOP: begin
        tab_raddr_o = tab_addr(32'd0, ent2node(lo_q));
        state_d = S_QTOPW;
      end
      S_QTOPW: begin
        top_d = (lo_q != '0) ? tab_rdata_i : '0;
        state_d = S_QDT;
      end
      S_QDT: begin
        dep_raddr_o = ent2node(top_q);
        state_d = S_QDTW;
      end
      S_QDTW: begin
        dt  = (top_q != '0) ? dep_rdata_i : '0;
        sum = 13'(da_q) + 13'(db_q);
        sd  = $signed({1'b0, sum}) - $signed(14'({dt, 1'b0}));
        res_o.valid     = 1'b1;
        res_o.is_answer = 1'b1;
        res_o.ancestor  = (top_q == '0) ? '0 : FIELD_W'(32'(ent2node(top_q)));
        if (sd < 0) begin
          res_o.distance = '0;
        end else if (sd > 14'sd2047) begin
          res_o.distance = '1;
        end else begin
          res_o.distance = sd[DIST_W-1:0];
        end
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    // next node of the build sweep, then next level
    if (b_adv) begin
      if ({1'b0, i_q} == n_q - (NW+1)'(1)) begin
        i_d = '0;
        if (32'(k_q) == LEVELS - 2) begin
          res_o.valid = 1'b1;
          state_d = S_IDLE;
        end else begin
          k_d = k_q + LW'(1);
          state_d = S_BRD;
        end
      end else begin
        i_d = i_q + NW'(1);
        state_d = S_BRD;
      end
    end

    if (q_adv) begin
      diff_d = diff_q >> 1;
      if (32'(k_q) == LEVELS - 1) begin
        state_d = S_QCMP;
      end else begin
        k_d = k_q + LW'(1);
        state_d = S_QLIFT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d; i_q <= i_d; n_q <= n_d; a_q <= a_d; b_q <= b_d;
    da_q <= da_d; db_q <= db_d; diff_q <= diff_d;
    lo_q <= lo_d; hi_q <= hi_d; pl_q <= pl_d; top_q <= top_d;
  end

endmodule
`default_nettype wire

// ----- rtl/tree_lca_binary_lifting_core.sv -----
// top level of the binary lifting lowest common ancestor engine
`default_nettype none
// Binary lifting LCA engine. Load transactions write one node's parent and depth
// in the cycle they are accepted; build fills levels 1..LEVELS-1 of the ancestor
// memory for nodes below node_count, reading the node's entry at each level and,
// when it has an ancestor, that ancestor's entry, then writing the next level. A
// query does two depth reads and lifts through all LEVELS levels; when the lifted
// nodes still differ, a descent with two ancestor reads per level and a parent
// read follow. A final depth read gives the distance. The single read port of the
// ancestor memory serializes these reads. One transaction is in work at a time;
// its result sits in an output register.
module tree_lca_binary_lifting_core import lca_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int LEVELS    = LEVELS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [COUNT_W-1:0] cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         operation_i,
  input  wire logic [FIELD_W-1:0] first_node_i,
  input  wire logic [FIELD_W-1:0] second_node_i,
  input  wire logic               has_parent_i,
  input  wire logic [FIELD_W-1:0] node_depth_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic      [FIELD_W-1:0] ancestor_o,
  output logic      [DIST_W-1:0]  distance_o,
  output logic                    is_answer_o
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int EW = NW + 1;
  localparam int AW = $clog2(LEVELS * MAX_NODES);

  logic [COUNT_W-1:0] node_count_q;
  logic               out_valid_q;
  logic [FIELD_W-1:0] ancestor_q;
  logic [DIST_W-1:0]  distance_q;
  logic               is_answer_q;
  logic               out_free;
  lca_res_t           res;

  logic               tab_we;
  logic [AW-1:0]      tab_waddr, tab_raddr;
  logic [EW-1:0]      tab_wdata, tab_rdata;
  logic               dep_we;
  logic [NW-1:0]      dep_waddr, dep_raddr;
  logic [FIELD_W-1:0] dep_wdata, dep_rdata;

  assign out_free = !out_valid_q || out_ready_i;

  lca_ctrl #(
    .MAX_NODES(MAX_NODES),
    .LEVELS   (LEVELS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .out_free_i   (out_free),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .first_node_i (first_node_i),
    .second_node_i(second_node_i),
    .has_parent_i (has_parent_i),
    .node_depth_i (node_depth_i),
    .node_count_i (node_count_q),
    .tab_we_o     (tab_we),
    .tab_waddr_o  (tab_waddr),
    .tab_wdata_o  (tab_wdata),
    .tab_raddr_o  (tab_raddr),
    .tab_rdata_i  (tab_rdata),
    .dep_we_o     (dep_we),
    .dep_waddr_o  (dep_waddr),
    .dep_wdata_o  (dep_wdata),
    .dep_raddr_o  (dep_raddr),
    .dep_rdata_i  (dep_rdata),
    .res_o        (res)
  );

  // ancestor entries are node index plus one, zero for none
  lca_ram #(
    .WIDTH(EW),
    .DEPTH(LEVELS * MAX_NODES)
  ) u_tab_ram (
    .clk_i  (clk_i),
    .we_i   (tab_we),
    .waddr_i(tab_waddr),
    .wdata_i(tab_wdata),
    .raddr_i(tab_raddr),
    .rdata_o(tab_rdata)
  );

  lca_ram #(
    .WIDTH(FIELD_W),
    .DEPTH(MAX_NODES)
  ) u_dep_ram (
    .clk_i  (clk_i),
    .we_i   (dep_we),
    .waddr_i(dep_waddr),
    .wdata_i(dep_wdata),
    .raddr_i(dep_raddr),
    .rdata_o(dep_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= COUNT_W'(1);
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
      if (res.valid) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      ancestor_q  <= res.ancestor;
      distance_q  <= res.distance;
      is_answer_q <= res.is_answer;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ancestor_o  = ancestor_q;
  assign distance_o  = distance_q;
  assign is_answer_o = is_answer_q;

  a_res_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> out_free)
    else $error("result produced while output register is blocked");

  a_ack_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_answer_o |-> ancestor_o == '0 && distance_o == '0)
    else $error("acknowledge carries nonzero fields");

  a_load_acked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && operation_i == OP_LOAD |=> out_valid_o && !is_answer_o)
    else $error("load transaction not acknowledged next cycle");

endmodule
`default_nettype wire

// ----- tb/tree_lca_binary_lifting_core_tb.sv -----
// testbench for the binary lifting lowest common ancestor engine
module tree_lca_binary_lifting_core_tb;
  import lca_pkg::*;

  localparam int NODES      = 1024;
  localparam int LVLS       = 10;
  localparam int STALL_MAX  = 5;
  localparam int IDLE_LIMIT = 200000;
  localparam int DRAIN_GAP  = 60;

  typedef struct packed {
    logic [FIELD_W-1:0] ancestor;
    logic [DIST_W-1:0]  distance;
    logic               is_answer;
  } lca_answer_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         operation_i = OP_LOAD;
  logic [FIELD_W-1:0] first_node_i = '0;
  logic [FIELD_W-1:0] second_node_i = '0;
  logic               has_parent_i = 1'b0;
  logic [FIELD_W-1:0] node_depth_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [FIELD_W-1:0] ancestor_o;
  logic [DIST_W-1:0]  distance_o;
  logic               is_answer_o;

  tree_lca_binary_lifting_core dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // shadow of the engine: jump table kept as index+1, 0 means no ancestor
  int unsigned jump_tbl [LVLS][NODES];
  int unsigned depth_tbl [NODES];
  int unsigned count_reg = 1;

  lca_answer_t pending_answers [$];
  int errors = 0;
  int sent = 0;
  int answered = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;

  // tree under test
  int tree_parent [NODES];
  int tree_depth [NODES];

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, answered);
    errors++;
  endtask

  function automatic int unsigned step_up(int k, int unsigned e);
    return (e == 0) ? 0 : jump_tbl[k][(e - 1) % NODES];
  endfunction

  function automatic int unsigned depth_at(int unsigned e);
    return (e == 0) ? 0 : depth_tbl[(e - 1) % NODES];
  endfunction

  function automatic lca_answer_t predict_lca(op_e op, int a_in, int b_in, bit hp, int d);
    lca_answer_t r;
    int unsigned a, b, da, db, lo, hi, diff, top, pl, ph, n;
    int span;
    r = '0;
    case (op)
      OP_LOAD: begin
        jump_tbl[0][a_in] = hp ? b_in + 1 : 0;
        depth_tbl[a_in] = d;
      end
      OP_BUILD: begin
        n = (count_reg > NODES) ? NODES : count_reg;
        for (int k = 0; k + 1 < LVLS; k++)
          for (int i = 0; i < n; i++)
            jump_tbl[k + 1][i] = step_up(k, jump_tbl[k][i]);
      end
      OP_QUERY: begin
        a = a_in + 1;
        b = b_in + 1;
        da = depth_at(a);
        db = depth_at(b);
        lo = a;
        hi = b;
        if (da > db) begin
          lo = b;
          hi = a;
          diff = da - db;
        end else begin
          diff = db - da;
        end
        for (int k = 0; k < LVLS; k++)
          if (diff[k]) hi = step_up(k, hi);
        if (lo == hi) begin
          top = lo;
        end else begin
          for (int k = LVLS - 1; k >= 0; k--) begin
            pl = step_up(k, lo);
            ph = step_up(k, hi);
            if (pl != ph) begin
              lo = pl;
              hi = ph;
            end
          end
          top = step_up(0, lo);
        end
        span = int'(da) + int'(db) - 2 * int'(depth_at(top));
        if (span < 0) span = 0;
        if (span > 2047) span = 2047;
        r.ancestor = (top == 0) ? '0 : FIELD_W'(top - 1);
        r.distance = DIST_W'(span);
        r.is_answer = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_item(op_e op, int a, int b, bit hp, int d);
    int gap;
    gap = calm ? 0 : $urandom_range(0, STALL_MAX);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    operation_i <= op;
    first_node_i <= FIELD_W'(a);
    second_node_i <= FIELD_W'(b);
    has_parent_i <= hp;
    node_depth_i <= FIELD_W'(d);
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_answers.push_back(predict_lca(op, a, b, hp, d));
    sent++;
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_GAP) @(posedge clk_i);
  endtask

  task automatic set_count(int value);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= COUNT_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    count_reg = value;
  endtask

  // random tree over nodes 0..n-1, node 0 is the root; chain gives a path
  task automatic load_tree(int n, bit chain);
    for (int i = 0; i < n; i++) begin
      if (i == 0) begin
        tree_parent[i] = -1;
        tree_depth[i] = 0;
        send_item(OP_LOAD, 0, $urandom_range(0, NODES - 1), 1'b0, 0);
      end else begin
        tree_parent[i] = chain ? i - 1 : $urandom_range(0, i - 1);
        tree_depth[i] = tree_depth[tree_parent[i]] + 1;
        send_item(OP_LOAD, i, tree_parent[i], 1'b1, tree_depth[i]);
      end
    end
  endtask

  task automatic random_queries(int n, int cnt);
    for (int i = 0; i < cnt; i++)
      send_item(OP_QUERY, $urandom_range(0, n - 1), $urandom_range(0, n - 1), 1'b0, 0);
  endtask

  task automatic test_reset_count;
    send_item(OP_LOAD, 0, 5, 1'b0, 0);
    send_item(OP_BUILD, 0, 0, 1'b0, 0);
    send_item(OP_QUERY, 0, 0, 1'b0, 0);
    send_item(OP_NONE, 1023, 1023, 1'b1, 1023);
    send_item(OP_QUERY, 0, 0, 1'b0, 0);
  endtask

  task automatic test_field_extremes;
    send_item(OP_LOAD, 1023, 1023, 1'b1, 1023);
    send_item(OP_LOAD, 1023, 0, 1'b0, 0);
    send_item(OP_LOAD, 512, 341, 1'b1, 682);
  endtask

  task automatic test_chain;
    set_count(16);
    load_tree(16, 1'b1);
    send_item(OP_BUILD, 0, 0, 1'b0, 0);
    send_item(OP_QUERY, 15, 0, 1'b0, 0);
    send_item(OP_QUERY, 0, 15, 1'b0, 0);
    send_item(OP_QUERY, 7, 7, 1'b0, 0);
  endtask

  // depths that do not match the tree: lifting falls off the root
  task automatic test_bad_depths;
    set_count(8);
    for (int i = 0; i < 8; i++)
      send_item(OP_LOAD, i, (i == 0) ? 0 : $urandom_range(0, i - 1), i != 0,
                $urandom_range(0, 1023));
    send_item(OP_BUILD, 0, 0, 1'b0, 0);
    random_queries(8, 6);
  endtask

  // zero count builds nothing, loads after a build touch level 0 only
  task automatic test_stale_levels;
    set_count(20);
    load_tree(20, 1'b0);
    send_item(OP_BUILD, 0, 0, 1'b0, 0);
    set_count(0);
    send_item(OP_LOAD, 19, 3, 1'b1, 9);
    send_item(OP_BUILD, 0, 0, 1'b0, 0);
    random_queries(20, 6);
  endtask

  task automatic test_full_tree;
    set_count(2047);
    calm = 1'b1;
    load_tree(NODES, $urandom_range(0, 1));
    calm = 1'b0;
    send_item(OP_BUILD, 0, 0, 1'b0, 0);
    random_queries(NODES, 10);
    send_item(OP_QUERY, 1023, 0, 1'b0, 0);
    set_count(1024);
    send_item(OP_BUILD, 0, 0, 1'b0, 0);
    random_queries(NODES, 10);
  endtask

  task automatic test_random;
    int n, start;
    start = sent;
    while (sent - start < 500) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 200) : $urandom_range(1, 30);
      set_count(n);
      calm = ($urandom_range(0, 3) == 0);
      load_tree(n, $urandom_range(0, 4) == 0);
      send_item(OP_BUILD, 0, 0, 1'b0, 0);
      random_queries(n, $urandom_range(5, 25));
      if ($urandom_range(0, 2) == 0) drain();
      if ($urandom_range(0, 2) == 0) send_item(OP_NONE, $urandom_range(0, 1023),
          $urandom_range(0, 1023), $urandom_range(0, 1), $urandom_range(0, 1023));
      random_queries(n, $urandom_range(1, 10));
    end
    calm = 1'b0;
  endtask

  // result side: random stall after every transaction unless calm
  int out_stall = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ready_i && out_valid_o) begin
        out_stall = calm ? 0 : $urandom_range(0, STALL_MAX);
        if (out_stall > 0) out_ready_i <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        if (out_stall == 0) out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    lca_answer_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_answers.size() == 0) begin
        report("unexpected result transaction", 1, 0);
      end else begin
        want = pending_answers.pop_front();
        if (ancestor_o !== want.ancestor) report("ancestor", ancestor_o, want.ancestor);
        if (distance_o !== want.distance) report("distance", distance_o, want.distance);
        if (is_answer_o !== want.is_answer) report("is_answer", is_answer_o, want.is_answer);
      end
      answered++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_count();
    test_field_extremes();
    test_chain();
    test_bad_depths();
    test_stale_levels();
    test_full_tree();
    test_random();
    drain();
    $display("covered %0d transactions in, %0d results out, node counts 0 to 2047",
             sent, answered);
    $display("trees from a single root to all 1024 nodes, with stale levels and bad depths");
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- tree_lca_binary_lifting_core.f -----
rtl/lca_pkg.sv
rtl/lca_ram.sv
rtl/lca_ctrl.sv
rtl/tree_lca_binary_lifting_core.sv
tb/tree_lca_binary_lifting_core_tb.sv
